// ===== hw/rtl/per_id_message_stats_table_assert.svh =====
// Assertion macros for the per-id message statistics table.
`ifndef PER_ID_MESSAGE_STATS_TABLE_ASSERT_SVH
`define PER_ID_MESSAGE_STATS_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PIMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PIMS_ASSERT(label, clk, rst_n, prop, msg)
`define PIMS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/pims_pkg.sv =====
// ----------------------------------------------------------------------------
// pims_pkg
// Types, constants and saturating helpers of the message statistics table.
// ----------------------------------------------------------------------------
package pims_pkg;

    localparam int ID_ENTRIES = 64;
    localparam int TYPE_COUNT = 4;
    localparam int IDX_W      = (ID_ENTRIES > 1) ? $clog2(ID_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ID_ENTRIES + 1);
    localparam int TYPE_W     = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int TOTAL_W    = 34;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TYPE_IGN = 2'd2;

    localparam logic [1:0] OC_SUCCESS = 2'd0;
    localparam logic [1:0] OC_FAIL    = 2'd1;
    localparam logic [1:0] OC_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [31:0] msg_id;
        logic [1:0]  outcome;
        logic [23:0] msg_length;
        logic [31:0] process_us;
        logic [3:0]  msg_type;
        logic [15:0] repeat_count;
    } item_t;

    typedef struct packed {
        logic [31:0] success;
        logic [31:0] fail;
        logic [31:0] timeout;
        logic [47:0] bytes;
        logic [47:0] tsum;
        logic [31:0] tmax;
    } stats_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic [31:0] success_total;
        logic [31:0] fail_total;
        logic [31:0] timeout_total;
        logic [47:0] byte_total;
        logic [47:0] time_sum_us;
        logic [31:0] time_max_us;
        logic [47:0] time_avg_us;
        logic [31:0] type_total;
    } result_t;

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage

// ===== hw/rtl/pims_in_if.sv =====
// ----------------------------------------------------------------------------
// pims_in_if
// Message record channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pims_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_id;
    logic [1:0]  outcome;
    logic [23:0] msg_length;
    logic [31:0] process_us;
    logic [3:0]  msg_type;
    logic [15:0] repeat_count;

    modport source (output valid, msg_id, outcome, msg_length, process_us, msg_type,
                    repeat_count, input ready);
    modport sink (input valid, msg_id, outcome, msg_length, process_us, msg_type,
                  repeat_count, output ready);
endinterface

// ===== hw/rtl/pims_out_if.sv =====
// ----------------------------------------------------------------------------
// pims_out_if
// Statistics result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pims_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] success_total;
    logic [31:0] fail_total;
    logic [31:0] timeout_total;
    logic [47:0] byte_total;
    logic [47:0] time_sum_us;
    logic [31:0] time_max_us;
    logic [47:0] time_avg_us;
    logic [31:0] type_total;

    modport source (output valid, status, entry_index, success_total, fail_total,
                    timeout_total, byte_total, time_sum_us, time_max_us, time_avg_us,
                    type_total, input ready);
    modport sink (input valid, status, entry_index, success_total, fail_total,
                  timeout_total, byte_total, time_sum_us, time_max_us, time_avg_us,
                  type_total, output ready);
endinterface

// ===== hw/rtl/pims_ram.sv =====
// ----------------------------------------------------------------------------
// pims_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pims_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/pims_divider.sv =====
// ----------------------------------------------------------------------------
// pims_divider
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module pims_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [47:0]                  dividend,
    input  logic [pims_pkg::TOTAL_W-1:0] divisor,
    output logic                         done,
    output logic [47:0]                  quotient
);
    import pims_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [47:0]        q_reg, q_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] d_reg, d_next;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        shifted   = {rem_reg, q_reg[47]};
        diff      = shifted - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so the low bits hold it.
            if (!diff[TOTAL_W])
            begin
                rem_next = diff[TOTAL_W-1:0];
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TOTAL_W-1:0];
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ===== hw/rtl/per_id_message_stats_table.sv =====
// Flow: the key scan visits each used slot in S_SCAN then S_CMP; S_SCAN then appends the
// id or reports full, S_UPD updates the slot and registers the result, S_DIV waits on the
// divider when the total is nonzero, and S_DONE loads the output register. One message is
// handled at a time: a new one is taken only in S_IDLE. A finished result waits in an output register.
// Reset: the fill count and per-type counters clear at once; slot statistics read as
// zero when a slot is appended, so the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
// per_id_message_stats_table
// Per-id message statistics: key lookup, counter update and average time.
// ----------------------------------------------------------------------------
`include "per_id_message_stats_table_assert.svh"
module per_id_message_stats_table (
    input  logic       clk,
    input  logic       rst_n,
    pims_in_if.sink    msg,
    pims_out_if.source res
);
    import pims_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_CMP  = 6'b000100,
        S_UPD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic               new_reg, new_next;
    result_t            build_reg, build_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        tcnt_reg [TYPE_COUNT][4];
    logic [31:0]        tcnt_next [TYPE_COUNT][4];

    logic               key_we;
    logic [IDX_W-1:0]   key_addr;
    logic [31:0]        key_rdata;
    logic               st_we;
    logic [IDX_W-1:0]   st_addr;
    stats_t             st_rdata;
    stats_t             st_base;
    stats_t             st_new;
    logic [TOTAL_W-1:0] total;
    logic               div_start;
    logic               div_done;
    logic [47:0]        div_q;
    logic [TYPE_W-1:0]  tsel;
    logic               type_ok;

    pims_ram #(.WIDTH(32), .DEPTH(ID_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (item_reg.msg_id),
        .rdata (key_rdata)
    );

    pims_ram #(.WIDTH($bits(stats_t)), .DEPTH(ID_ENTRIES)) u_stats_ram (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_new),
        .rdata (st_rdata)
    );

    pims_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (st_new.tsum),
        .divisor  (total),
        .done     (div_done),
        .quotient (div_q)
    );

    assign key_we   = (state_reg == S_SCAN) && (idx_reg == used_reg)
                      && (used_reg < CNT_W'(ID_ENTRIES));
    assign key_addr = key_we ? used_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign st_we    = (state_reg == S_UPD);
    assign st_addr  = st_we ? slot_reg : idx_reg[IDX_W-1:0];
    assign tsel     = item_reg.msg_type[TYPE_W-1:0];
    assign type_ok  = 32'(item_reg.msg_type) < TYPE_COUNT;

    always_comb
    begin
        // A freshly appended slot starts from zero whatever the RAM holds.
        st_base = new_reg ? stats_t'('0) : st_rdata;
        st_new  = st_base;
        case (item_reg.outcome)
            OC_SUCCESS: st_new.success = sat32(st_base.success, 32'(item_reg.repeat_count));
            OC_FAIL:    st_new.fail    = sat32(st_base.fail, 32'(item_reg.repeat_count));
            OC_TIMEOUT: st_new.timeout = sat32(st_base.timeout, 32'(item_reg.repeat_count));
            default:    st_new.success = st_base.success;
        endcase
        st_new.bytes = sat48(st_base.bytes, 48'(item_reg.msg_length));
        st_new.tsum  = sat48(st_base.tsum, 48'(item_reg.process_us));
        st_new.tmax  = (st_base.tmax < item_reg.process_us) ? item_reg.process_us
                                                            : st_base.tmax;
        total = TOTAL_W'(st_new.success) + TOTAL_W'(st_new.fail)
                + TOTAL_W'(st_new.timeout);
    end

    assign div_start = (state_reg == S_UPD) && (total != '0);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        slot_next      = slot_reg;
        new_next       = new_reg;
        build_next     = build_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tcnt_next      = tcnt_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    item_next.msg_id       = msg.msg_id;
                    item_next.outcome      = msg.outcome;
                    item_next.msg_length   = msg.msg_length;
                    item_next.process_us   = msg.process_us;
                    item_next.msg_type     = msg.msg_type;
                    item_next.repeat_count = msg.repeat_count;
                    idx_next               = '0;
                    state_next             = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == used_reg)
                begin
                    if (used_reg >= CNT_W'(ID_ENTRIES))
                    begin
                        build_next        = '0;
                        build_next.status = ST_FULL;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        slot_next  = used_reg[IDX_W-1:0];
                        new_next   = 1'b1;
                        used_next  = used_reg + CNT_W'(1);
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_rdata == item_reg.msg_id)
                begin
                    slot_next  = idx_reg[IDX_W-1:0];
                    new_next   = 1'b0;
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_UPD:
            begin
                build_next.status        = type_ok ? ST_OK : ST_TYPE_IGN;
                build_next.entry_index   = 6'(slot_reg);
                build_next.success_total = st_new.success;
                build_next.fail_total    = st_new.fail;
                build_next.timeout_total = st_new.timeout;
                build_next.byte_total    = st_new.bytes;
                build_next.time_sum_us   = st_new.tsum;
                build_next.time_max_us   = st_new.tmax;
                build_next.time_avg_us   = '0;
                build_next.type_total    = '0;
                if (type_ok)
                begin
                    tcnt_next[tsel][0]    = sat32(tcnt_reg[tsel][0], 32'd1);
                    build_next.type_total = tcnt_next[tsel][0];
                    if (item_reg.outcome != 2'd3)
                    begin
                        tcnt_next[tsel][item_reg.outcome + 2'd1] =
                            sat32(tcnt_reg[tsel][item_reg.outcome + 2'd1], 32'd1);
                    end
                end
                state_next = div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    build_next.time_avg_us = div_q;
                    state_next             = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = build_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TYPE_COUNT; t++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    tcnt_reg[t][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            tcnt_reg      <= tcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        new_reg   <= new_next;
        build_reg <= build_next;
        out_reg   <= out_next;
    end

    assign msg.ready         = (state_reg == S_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.status        = out_reg.status;
    assign res.entry_index   = out_reg.entry_index;
    assign res.success_total = out_reg.success_total;
    assign res.fail_total    = out_reg.fail_total;
    assign res.timeout_total = out_reg.timeout_total;
    assign res.byte_total    = out_reg.byte_total;
    assign res.time_sum_us   = out_reg.time_sum_us;
    assign res.time_max_us   = out_reg.time_max_us;
    assign res.time_avg_us   = out_reg.time_avg_us;
    assign res.type_total    = out_reg.type_total;

    `PIMS_ASSERT(a_used_bound, clk, rst_n, used_reg <= CNT_W'(ID_ENTRIES), "fill count overflow")
    `PIMS_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result without finish")
    `PIMS_ASSERT(a_div_only_busy, clk, rst_n, div_done |-> state_reg == S_DIV, "divider done outside wait")
endmodule
